// ===== hdl/lrm_pkg.sv =====
package lrm_pkg;

  localparam int NUM_VARS   = 64;
  localparam int DATA_WIDTH = 32;
  localparam int VAR_AW     = $clog2(NUM_VARS);

  localparam int IDX_W   = 6;
  localparam int RADIX_W = 6;
  localparam int CHAR_W  = 8;
  localparam int VALUE_W = 32;

  localparam int MAX_DIGITS = DATA_WIDTH;
  localparam int DIG_AW     = $clog2(MAX_DIGITS);
  localparam int DIG_CNT_W  = DIG_AW + 1;

  // quotient bits resolved per cycle by the shared divider
  localparam int DIV_STEP   = 4;
  localparam int DIV_CYCLES = (DATA_WIDTH + DIV_STEP - 1) / DIV_STEP;
  localparam int DIV_W      = DIV_CYCLES * DIV_STEP;
  localparam int DIV_CNT_W  = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] DIGIT_TEN = RADIX_W'(10);

  localparam logic [CHAR_W-1:0] CHAR_0    = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_9    = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_UA   = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UZ   = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_LA   = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LZ   = 8'h7A;
  localparam logic [CHAR_W-1:0] CASE_FOLD = 8'd32;

  typedef enum logic [3:0] {
    CMD_OR       = 4'd0,
    CMD_AND      = 4'd1,
    CMD_IMP      = 4'd2,
    CMD_REVIMP   = 4'd3,
    CMD_EQU      = 4'd4,
    CMD_XOR      = 4'd5,
    CMD_COIMP    = 4'd6,
    CMD_NAND     = 4'd7,
    CMD_NOR      = 4'd8,
    CMD_NOT      = 4'd9,
    CMD_READCHAR = 4'd10,
    CMD_WRITE    = 4'd11
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_LOGIC,
    ST_CHAR,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [3:0]         command;
    logic [IDX_W-1:0]   reg_dest;
    logic [IDX_W-1:0]   reg_a;
    logic [IDX_W-1:0]   reg_b;
    logic [RADIX_W-1:0] radix;
    logic [CHAR_W-1:0]  in_char;
    logic               char_last;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [CHAR_W-1:0]  digit_char;
    logic               last;
    logic               status;
  } out_item_t;

  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) res = RADIX_MIN;
    if (r > RADIX_MAX) res = RADIX_MAX;
    return res;
  endfunction

  function automatic logic var_in_range(input logic [IDX_W-1:0] idx);
    return int'(idx) < NUM_VARS;
  endfunction

endpackage

// ===== hdl/lrm_ram.sv =====
module lrm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/logic_register_machine_radix_io.sv =====
// a logic command reads A, then B, then registers its result;
// readchar registers a result on the last char; write reads A and B, then the
// shared 4-bit-per-cycle divider yields each digit, then one digit per cycle
// goes out; busy holds until the last result is registered, so one command at a time
// each result is strobed for one cycle; the receiver cannot stall results
// reset: synchronous, active low; clears state, valid bits and read accumulator
module logic_register_machine_radix_io import lrm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_strobe,
  output out_item_t out_item
);

  state_t state_r, state_nxt;
  in_item_t item_r, item_nxt;

  logic [NUM_VARS-1:0]   valid_r, valid_nxt;
  logic [DATA_WIDTH-1:0] a_r, a_nxt;
  logic                  rd_ok_r, rd_ok_nxt;
  logic [DATA_WIDTH-1:0] acc_r, acc_nxt;
  logic                  err_r, err_nxt;

  logic [DIV_W-1:0]     work_r, work_nxt;
  logic [RADIX_W-1:0]   rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] divcnt_r, divcnt_nxt;
  logic [DIG_CNT_W-1:0] ndig_r, ndig_nxt;
  logic [RADIX_W-1:0]   digbuf_r [MAX_DIGITS];
  logic                 digbuf_we;

  logic      out_strobe_r, out_strobe_nxt;
  out_item_t out_item_r, out_item_nxt;

  logic                  ram_we;
  logic [VAR_AW-1:0]     ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata, ram_val;

  logic [DIV_W-1:0]   div_work;
  logic [RADIX_W-1:0] div_rem;
  logic               div_last, div_done;

  lrm_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(NUM_VARS)
  ) u_var_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  // entries never written or out of range read as zero
  assign ram_val = rd_ok_r ? ram_rdata : '0;

  // shared divider: DIV_STEP restoring steps on the remainder per cycle
  always_comb begin
    logic [RADIX_W:0]   trial;
    logic [RADIX_W-1:0] rem_v;
    logic [DIV_W-1:0]   work_v;
    rem_v  = rem_r;
    work_v = work_r;
    trial  = '0;
    for (int i = 0; i < DIV_STEP; i++) begin
      trial  = {rem_v, work_v[DIV_W-1]};
      work_v = {work_v[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, item_r.radix}) begin
        trial     = trial - {1'b0, item_r.radix};
        work_v[0] = 1'b1;
      end
      rem_v = trial[RADIX_W-1:0];
    end
    div_work = work_v;
    div_rem  = rem_v;
  end

  assign div_last = (divcnt_r == DIV_CNT_W'(DIV_CYCLES - 1));
  assign div_done = (div_work == '0) || (ndig_r == DIG_CNT_W'(MAX_DIGITS - 1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_item.command inside {[CMD_OR:CMD_NOT], CMD_WRITE}) begin
            state_nxt = ST_RD_A;
          end else if (in_item.command == CMD_READCHAR) begin
            state_nxt = ST_CHAR;
          end
        end
      end
      ST_RD_A:  state_nxt = ST_RD_B;
      ST_RD_B:  state_nxt = (item_r.command == CMD_WRITE) ? ST_DIV : ST_LOGIC;
      ST_LOGIC: state_nxt = ST_IDLE;
      ST_CHAR:  state_nxt = ST_IDLE;
      ST_DIV: begin
        if (div_last && div_done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (ndig_r == DIG_CNT_W'(1)) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    logic [DATA_WIDTH-1:0] res;
    logic [CHAR_W-1:0]     ch;
    logic [RADIX_W-1:0]    dig;
    logic                  ok;
    logic [DATA_WIDTH-1:0] acc_v;
    logic                  err_v;
    logic [DIG_CNT_W-1:0]  emit_cnt;
    logic [RADIX_W-1:0]    emit_dig;

    item_nxt       = item_r;
    valid_nxt      = valid_r;
    a_nxt          = a_r;
    rd_ok_nxt      = rd_ok_r;
    acc_nxt        = acc_r;
    err_nxt        = err_r;
    work_nxt       = work_r;
    rem_nxt        = rem_r;
    divcnt_nxt     = divcnt_r;
    ndig_nxt       = ndig_r;
    digbuf_we      = 1'b0;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    ram_we         = 1'b0;
    ram_waddr      = VAR_AW'(item_r.reg_dest);
    ram_wdata      = '0;
    ram_raddr      = VAR_AW'(item_r.reg_a);
    res            = '0;
    dig            = '0;
    ok             = 1'b1;
    acc_v          = acc_r;
    err_v          = err_r;
    emit_cnt       = ndig_r - DIG_CNT_W'(1);
    emit_dig       = digbuf_r[emit_cnt[DIG_AW-1:0]];

    // fold lowercase and decode the digit of a read character
    ch = item_r.in_char;
    if (ch inside {[CHAR_LA:CHAR_LZ]}) ch = ch - CASE_FOLD;
    if (ch inside {[CHAR_0:CHAR_9]}) begin
      dig = RADIX_W'(ch - CHAR_0);
    end else if (ch inside {[CHAR_UA:CHAR_UZ]}) begin
      dig = RADIX_W'(ch - CHAR_UA) + DIGIT_TEN;
    end else begin
      ok = 1'b0;
    end
    if (dig >= item_r.radix) ok = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          item_nxt       = in_item;
          item_nxt.radix = clamp_radix(in_item.radix);
        end
      end
      ST_RD_A: begin
        ram_raddr = VAR_AW'(item_r.reg_a);
        rd_ok_nxt = var_in_range(item_r.reg_a) && valid_r[VAR_AW'(item_r.reg_a)];
      end
      ST_RD_B: begin
        a_nxt      = ram_val;
        ram_raddr  = VAR_AW'(item_r.reg_b);
        rd_ok_nxt  = var_in_range(item_r.reg_b) && valid_r[VAR_AW'(item_r.reg_b)];
        work_nxt   = DIV_W'(ram_val);
        rem_nxt    = '0;
        divcnt_nxt = '0;
        ndig_nxt   = '0;
      end
      ST_LOGIC: begin
        case (item_r.command)
          CMD_OR:     res = a_r | ram_val;
          CMD_AND:    res = a_r & ram_val;
          CMD_IMP:    res = ~a_r | ram_val;
          CMD_REVIMP: res = a_r | ~ram_val;
          CMD_EQU:    res = ~(a_r ^ ram_val);
          CMD_XOR:    res = a_r ^ ram_val;
          CMD_COIMP:  res = a_r & ~ram_val;
          CMD_NAND:   res = ~(a_r & ram_val);
          CMD_NOR:    res = ~(a_r | ram_val);
          default:    res = ~a_r;
        endcase
        ram_waddr = VAR_AW'(item_r.reg_dest);
        ram_wdata = res;
        if (var_in_range(item_r.reg_dest)) begin
          ram_we                                = 1'b1;
          valid_nxt[VAR_AW'(item_r.reg_dest)] = 1'b1;
        end
        out_strobe_nxt          = 1'b1;
        out_item_nxt.value      = VALUE_W'(res);
        out_item_nxt.digit_char = '0;
        out_item_nxt.last       = 1'b1;
        out_item_nxt.status     = 1'b0;
      end
      ST_CHAR: begin
        if (ok) begin
          acc_v = DATA_WIDTH'(acc_r * DATA_WIDTH'(item_r.radix)) + DATA_WIDTH'(dig);
        end else begin
          err_v = 1'b1;
        end
        acc_nxt = acc_v;
        err_nxt = err_v;
        if (item_r.char_last) begin
          ram_waddr = VAR_AW'(item_r.reg_a);
          ram_wdata = acc_v;
          if (!err_v && var_in_range(item_r.reg_a)) begin
            ram_we                             = 1'b1;
            valid_nxt[VAR_AW'(item_r.reg_a)] = 1'b1;
          end
          out_strobe_nxt          = 1'b1;
          out_item_nxt.value      = err_v ? '0 : VALUE_W'(acc_v);
          out_item_nxt.digit_char = '0;
          out_item_nxt.last       = 1'b1;
          out_item_nxt.status     = err_v;
          acc_nxt                 = '0;
          err_nxt                 = 1'b0;
        end
      end
      ST_DIV: begin
        work_nxt   = div_work;
        rem_nxt    = div_rem;
        divcnt_nxt = divcnt_r + DIV_CNT_W'(1);
        if (div_last) begin
          // remainder is the next digit, quotient feeds the next pass
          digbuf_we  = 1'b1;
          ndig_nxt   = ndig_r + DIG_CNT_W'(1);
          rem_nxt    = '0;
          divcnt_nxt = '0;
        end
      end
      ST_EMIT: begin
        ndig_nxt                = emit_cnt;
        out_strobe_nxt          = 1'b1;
        out_item_nxt.value      = VALUE_W'(a_r);
        out_item_nxt.digit_char = (emit_dig > RADIX_W'(9))
                                  ? CHAR_W'(emit_dig - DIGIT_TEN) + CHAR_UA
                                  : CHAR_W'(emit_dig) + CHAR_0;
        out_item_nxt.last       = (ndig_r == DIG_CNT_W'(1));
        out_item_nxt.status     = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      valid_r      <= '0;
      acc_r        <= '0;
      err_r        <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      acc_r        <= acc_nxt;
      err_r        <= err_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    a_r        <= a_nxt;
    rd_ok_r    <= rd_ok_nxt;
    work_r     <= work_nxt;
    rem_r      <= rem_nxt;
    divcnt_r   <= divcnt_nxt;
    ndig_r     <= ndig_nxt;
    out_item_r <= out_item_nxt;
    if (digbuf_we) begin
      digbuf_r[ndig_r[DIG_AW-1:0]] <= div_rem;
    end
  end

endmodule

// ===== hdl/lrm_checker.sv =====
module lrm_checker import lrm_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_item_t  in_item,
  input logic      out_strobe,
  input out_item_t out_item
);

  // every result comes out of work that was in progress the cycle before
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result without work in progress");

  // a valid command moves the block out of idle
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.command <= CMD_WRITE) |=> busy)
    else $error("block not busy after command transfer");

  // digits of a write come back to back with the same value
  a_digits_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_item.last) |=> (out_strobe && $stable(out_item.value)))
    else $error("gap or value change within a write");

  // a failed read reports zero and no digit
  a_error_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.status) |->
      (out_item.value == '0 && out_item.digit_char == '0 && out_item.last))
    else $error("error result carries data");

endmodule

bind logic_register_machine_radix_io lrm_checker u_lrm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_strobe(out_strobe),
  .out_item  (out_item)
);

// ===== tb/lrm_radix_io_checker.sv =====
module lrm_radix_io_checker import lrm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_item_t  in_item,
  input  logic      out_strobe,
  input  out_item_t out_item,
  output int        n_fail,
  output int        n_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [VALUE_W-1:0] var_file [NUM_VARS];
  logic [VALUE_W-1:0] read_acc;
  logic               read_err;
  out_item_t          out_due [$];
  out_item_t          want;

  function automatic out_item_t pack_out(logic [VALUE_W-1:0] v, logic [CHAR_W-1:0] c,
                                         logic l, logic s);
    out_item_t o;
    o.value = v;
    o.digit_char = c;
    o.last = l;
    o.status = s;
    return o;
  endfunction

  task automatic queue_result(input out_item_t o);
    out_due = {out_due, o};
  endtask

  task automatic note_mismatch(string field, logic [VALUE_W-1:0] e, logic [VALUE_W-1:0] a);
    n_fail++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, e, a);
  endtask

  // executes one instruction on the private copy of the variable file
  task automatic execute_cmd(input in_item_t it);
    logic [VALUE_W-1:0] a, b, r, v;
    logic [RADIX_W-1:0] rdx;
    logic [CHAR_W-1:0]  ch, dchar;
    logic [5:0]         dig [MAX_DIGITS];
    int                 n, d, k;
    bit                 ok;
    a = var_file[it.reg_a];
    b = var_file[it.reg_b];
    rdx = it.radix;
    if (rdx < RADIX_MIN) rdx = RADIX_MIN;
    if (rdx > RADIX_MAX) rdx = RADIX_MAX;
    if (it.command <= CMD_NOT) begin
      case (it.command)
        CMD_OR:     r = a | b;
        CMD_AND:    r = a & b;
        CMD_IMP:    r = ~a | b;
        CMD_REVIMP: r = a | ~b;
        CMD_EQU:    r = ~(a ^ b);
        CMD_XOR:    r = a ^ b;
        CMD_COIMP:  r = a & ~b;
        CMD_NAND:   r = ~(a & b);
        CMD_NOR:    r = ~(a | b);
        default:    r = ~a;
      endcase
      var_file[it.reg_dest] = r;
      queue_result(pack_out(r, '0, 1'b1, 1'b0));
    end else if (it.command == CMD_READCHAR) begin
      ch = it.in_char;
      if (ch >= CHAR_LA && ch <= CHAR_LZ) ch = ch - CASE_FOLD;
      ok = 1'b1;
      d = 0;
      if (ch >= CHAR_0 && ch <= CHAR_9) d = int'(ch - CHAR_0);
      else if (ch >= CHAR_UA && ch <= CHAR_UZ) d = int'(ch - CHAR_UA) + 10;
      else ok = 1'b0;
      if (ok && d >= rdx) ok = 1'b0;
      // accumulator wraps at the variable width
      if (ok) read_acc = read_acc * rdx + d;
      else read_err = 1'b1;
      if (it.char_last) begin
        if (read_err) begin
          queue_result(pack_out('0, '0, 1'b1, 1'b1));
        end else begin
          var_file[it.reg_a] = read_acc;
          queue_result(pack_out(read_acc, '0, 1'b1, 1'b0));
        end
        read_acc = '0;
        read_err = 1'b0;
      end
    end else if (it.command == CMD_WRITE) begin
      v = a;
      n = 0;
      do begin
        dig[n] = 6'(v % rdx);
        v = v / rdx;
        n++;
      end while (v != 0 && n < MAX_DIGITS);
      for (k = n - 1; k >= 0; k--) begin
        dchar = (dig[k] > 9) ? CHAR_W'(CHAR_UA + dig[k] - 10) : CHAR_W'(CHAR_0 + dig[k]);
        queue_result(pack_out(a, dchar, k == 0, 1'b0));
      end
    end
    // unused command codes leave everything untouched
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (var_file[i]) var_file[i] = '0;
      read_acc = '0;
      read_err = 1'b0;
      out_due.delete();
    end else begin
      // compare before predicting: a result can never belong to the item taken this edge
      if (out_strobe) begin
        if (out_due.size() == 0) begin
          n_fail++;
          $display("%0t: unexpected result, expected none, actual %0h", $time, out_item);
        end else begin
          want = out_due.pop_front();
          if (out_item.value !== want.value)
            note_mismatch("value", want.value, out_item.value);
          if (out_item.digit_char !== want.digit_char)
            note_mismatch("digit_char", want.digit_char, out_item.digit_char);
          if (out_item.last !== want.last)
            note_mismatch("last", want.last, out_item.last);
          if (out_item.status !== want.status)
            note_mismatch("status", want.status, out_item.status);
        end
      end
      if (start && !busy) execute_cmd(in_item);
    end
    n_pending = out_due.size();
  end

endmodule

// ===== tb/logic_register_machine_radix_io_tb.sv =====
module logic_register_machine_radix_io_tb import lrm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [3:0] CMD_FIRST_UNUSED = 4'(CMD_WRITE + 1);
  localparam logic [3:0] CMD_LAST_UNUSED  = '1;
  localparam int         NUM_ITEMS        = 430;
  localparam int         QUIET_TAIL       = 60;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_strobe;
  out_item_t out_item;
  int        n_fail;
  int        n_pending;
  int        items_done;
  bit        gaps_on;
  int        pick;
  int        c;

  logic_register_machine_radix_io dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  lrm_radix_io_checker checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item),
    .n_fail    (n_fail),
    .n_pending (n_pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // all fields random so unused ones toggle too
  function automatic in_item_t rand_item(logic [3:0] cmd);
    logic [63:0] r;
    in_item_t    it;
    r = {$urandom, $urandom};
    it = r[$bits(in_item_t)-1:0];
    it.command = cmd;
    return it;
  endfunction

  function automatic in_item_t logic_item(logic [3:0] cmd, logic [5:0] rd, logic [5:0] ra,
                                          logic [5:0] rb);
    in_item_t it;
    it = rand_item(cmd);
    it.reg_dest = rd;
    it.reg_a = ra;
    it.reg_b = rb;
    return it;
  endfunction

  function automatic in_item_t char_item(logic [7:0] ch, logic [5:0] rdx, logic last,
                                         logic [5:0] ra);
    in_item_t it;
    it = rand_item(CMD_READCHAR);
    it.in_char = ch;
    it.radix = rdx;
    it.char_last = last;
    it.reg_a = ra;
    return it;
  endfunction

  function automatic in_item_t write_item(logic [5:0] ra, logic [5:0] rdx);
    in_item_t it;
    it = rand_item(CMD_WRITE);
    it.reg_a = ra;
    it.radix = rdx;
    return it;
  endfunction

  task automatic send(input in_item_t it);
    @(negedge clk);
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    if (it.command <= CMD_WRITE) items_done++;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk);
    end
  endtask

  // one number string of valid digits in mixed case, optionally with a bad char
  // or a logic op slipped in after the first char
  task automatic send_number(input int len, input bit noisy, input bit interleave);
    in_item_t   it;
    logic [5:0] raw;
    int         rad, d, k;
    raw = 6'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(2, 36));
    rad = (raw < 2) ? 2 : (raw > 36) ? 36 : raw;
    for (k = 0; k < len; k++) begin
      d = $urandom_range(0, rad - 1);
      if (d < 10) it = char_item(CHAR_W'(CHAR_0 + d), raw, k == len - 1,
                                 6'($urandom_range(0, 63)));
      else it = char_item(CHAR_W'(($urandom_range(0, 1) ? CHAR_LA : CHAR_UA) + d - 10), raw,
                          k == len - 1, 6'($urandom_range(0, 63)));
      if (noisy && $urandom_range(0, len - 1) == 0) it.in_char = CHAR_W'($urandom_range(0, 255));
      send(it);
      if (interleave && k == 0 && len > 1) send(rand_item(4'($urandom_range(CMD_OR, CMD_NOT))));
    end
  endtask

  initial begin
    #(20_000_000);
    $display("logic_register_machine_radix_io_tb: FAIL");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    items_done = 0;
    gaps_on = 1'b1;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // all ones into v1, 0xBEEF into v3 through a mixed-case hex string
    send(logic_item(CMD_NOT, 1, 0, 63));
    send(char_item("b", 16, 1'b0, 0));
    send(char_item("E", 16, 1'b0, 0));
    send(char_item("e", 16, 1'b0, 0));
    send(char_item("F", 16, 1'b1, 3));
    for (c = CMD_OR; c <= CMD_NOR; c++) send(logic_item(4'(c), 6'(10 + c), 1, 3));
    send(write_item(1, 2));
    send(write_item(0, 0));
    send(write_item(3, 63));
    // non-alphanumeric, digit equal to radix, radix clamped high
    send(char_item("!", 10, 1'b1, 5));
    send(char_item("2", 2, 1'b1, 5));
    send(char_item("z", 63, 1'b1, 63));
    send(rand_item(CMD_FIRST_UNUSED));
    send(rand_item(CMD_LAST_UNUSED));
    // accumulator survives a command in between
    send(char_item("1", 1, 1'b0, 0));
    send(logic_item(CMD_XOR, 20, 1, 3));
    send(char_item("1", 1, 1'b1, 4));

    while (items_done < NUM_ITEMS) begin
      if (items_done >= NUM_ITEMS - QUIET_TAIL) gaps_on = 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 35) send(rand_item(4'($urandom_range(CMD_OR, CMD_NOT))));
      else if (pick < 65)
        send_number($urandom_range(1, 10), $urandom_range(0, 9) == 0,
                    $urandom_range(0, 9) == 0);
      else if (pick < 85) send(rand_item(CMD_WRITE));
      else if (pick < 90)
        send(rand_item(4'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED))));
      else send(rand_item(4'($urandom_range(CMD_OR, CMD_WRITE))));
    end

    @(negedge clk);
    start <= 1'b0;
    while (n_pending != 0) @(negedge clk);
    repeat (400) @(negedge clk);
    if (n_fail == 0 && n_pending == 0) begin
      $display("logic_register_machine_radix_io_tb: PASS");
    end else begin
      $display("logic_register_machine_radix_io_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/lrm_pkg.sv
hdl/lrm_ram.sv
hdl/logic_register_machine_radix_io.sv
hdl/lrm_checker.sv
tb/lrm_radix_io_checker.sv
tb/logic_register_machine_radix_io_tb.sv
